// ----- hdl/nfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator package
// Shared constants, operation codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Pool geometry. Slot indices are 10 bits wide, so the pool never exceeds
    // the slot space, whatever the maximum slot count.
    localparam int MAX_SLOTS  = 1024;
    localparam int SLOT_SPACE = 1024;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int EFF_MAX    = (MAX_SLOTS < SLOT_SPACE) ? MAX_SLOTS : SLOT_SPACE;

    // The in-use bits are held as words of this many slots each.
    localparam int WORD_W     = 32;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = (EFF_MAX + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Operation codes of an input beat.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat and arm the scan
        logic scan;      // issue word reads and examine returned words
        logic rd_free;   // read the word that holds the slot to free
        logic wr_alloc;  // write back the found word with its bit set
        logic wr_free;   // write back the slot's word with its bit cleared
        logic set_fail;  // record a failed request
        logic publish;   // move the pending result into the output register
    } nfsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_free;        // captured beat is a free request
        logic full;           // in-use count has reached the slot count
        logic free_in_range;  // slot to free lies below the slot count
        logic hit;            // the examined word holds a free slot in range
        logic miss;           // the last word of the scan held no free slot
    } nfsa_status_t;

endpackage

// ----- hdl/nfsa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic                                     we,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled; the read data always follows the address in the next cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/nfsa_datapath.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator datapath
// Holds the in-use bit store, the search start, the in-use count and the slot
// count register, runs the word scan and builds the result beat.
// ----------------------------------------------------------------------------
module nfsa_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [nfsa_pkg::COUNT_W-1:0]         cfg_wr_data,
    input  logic                                 in_op,
    input  logic [nfsa_pkg::SLOT_W-1:0]          in_slot,
    input  nfsa_pkg::nfsa_cmd_t                  cmd,
    output nfsa_pkg::nfsa_status_t               status,
    output logic                                 out_ok,
    output logic [nfsa_pkg::SLOT_W-1:0]          out_granted_slot,
    output logic [nfsa_pkg::COUNT_W-1:0]         out_in_use
);

    localparam int COUNT_W = nfsa_pkg::COUNT_W;
    localparam int SLOT_W  = nfsa_pkg::SLOT_W;
    localparam int WORD_W  = nfsa_pkg::WORD_W;
    localparam int OFF_W   = nfsa_pkg::OFF_W;
    localparam int WADDR_W = nfsa_pkg::WADDR_W;

    // Configuration and request registers.
    logic [COUNT_W-1:0] slot_count_reg;
    logic               op_reg;
    logic [SLOT_W-1:0]  slot_reg;

    // Allocator state.
    logic [SLOT_W-1:0]  search_start_reg, search_start_next;
    logic [COUNT_W-1:0] used_count_reg, used_count_next;
    logic [nfsa_pkg::NUM_WORDS-1:0] row_valid_reg;

    // Scan issue pointer.
    logic [WADDR_W-1:0] iss_word_reg, iss_word_next;
    logic               iss_phase_reg, iss_phase_next;
    logic               iss_active_reg, iss_active_next;

    // Word examine stage.
    logic               chk_valid_reg;
    logic [WADDR_W-1:0] chk_word_reg;
    logic               chk_phase_reg;
    logic               chk_last_reg;
    logic               chk_row_valid_reg;

    // Found word and slot, pending and published results.
    logic [WORD_W-1:0]  hold_word_reg;
    logic [SLOT_W-1:0]  pick_slot_reg;
    logic               res_ok_reg, res_ok_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic               out_ok_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COUNT_W-1:0] out_in_use_reg;

    // Combinational signals.
    logic [COUNT_W-1:0] eff_n;
    logic [COUNT_W-1:0] start_ext;
    logic               start_in;
    logic               wrap_en;
    logic [COUNT_W-1:0] p0_last;
    logic [COUNT_W-1:0] p1_top;
    logic [COUNT_W-1:0] p1_last;
    logic [WADDR_W-1:0] p0_first_word;
    logic [OFF_W-1:0]   p0_first_off;
    logic [WADDR_W-1:0] p0_last_word;
    logic [OFF_W-1:0]   p0_last_off;
    logic [WADDR_W-1:0] p1_last_word;
    logic [OFF_W-1:0]   p1_last_off;
    logic [WADDR_W-1:0] iss_end_word;
    logic               iss_at_end;
    logic               iss_last;
    logic [WADDR_W-1:0] lo_word;
    logic [OFF_W-1:0]   lo_off;
    logic [WADDR_W-1:0] hi_word;
    logic [OFF_W-1:0]   hi_off;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  scan_mask;
    logic [WORD_W-1:0]  free_bits;
    logic [WORD_W-1:0]  lowest_free;
    logic [OFF_W-1:0]   pick_off;
    logic               any_free;
    logic [WADDR_W-1:0] slot_word;
    logic [OFF_W-1:0]   slot_off;
    logic [WADDR_W-1:0] ram_addr;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    // Effective slot count: the register clamped to the range from 1 to the pool size.
    always_comb begin
        if (slot_count_reg == '0) begin
            eff_n = COUNT_W'(1);
        end else if (slot_count_reg > COUNT_W'(nfsa_pkg::EFF_MAX)) begin
            eff_n = COUNT_W'(nfsa_pkg::EFF_MAX);
        end else begin
            eff_n = slot_count_reg;
        end
    end

    // Bounds of the two scan parts: start to the last slot, then slot 0 up to the start.
    assign start_ext     = COUNT_W'(search_start_reg);
    assign start_in      = start_ext < eff_n;
    assign wrap_en       = search_start_reg != '0;
    assign p0_last       = eff_n - COUNT_W'(1);
    assign p1_top        = start_in ? start_ext : eff_n;
    assign p1_last       = p1_top - COUNT_W'(1);
    assign p0_first_word = WADDR_W'(search_start_reg >> OFF_W);
    assign p0_first_off  = search_start_reg[OFF_W-1:0];
    assign p0_last_word  = WADDR_W'(p0_last >> OFF_W);
    assign p0_last_off   = p0_last[OFF_W-1:0];
    assign p1_last_word  = WADDR_W'(p1_last >> OFF_W);
    assign p1_last_off   = p1_last[OFF_W-1:0];

    // Issue pointer: walks the words of the first part, then wraps once unless the start is slot 0.
    assign iss_end_word = iss_phase_reg ? p1_last_word : p0_last_word;
    assign iss_at_end   = iss_word_reg == iss_end_word;
    assign iss_last     = iss_at_end && (iss_phase_reg || !wrap_en);

    always_comb begin
        iss_word_next   = iss_word_reg;
        iss_phase_next  = iss_phase_reg;
        iss_active_next = iss_active_reg;
        if (cmd.load) begin
            iss_active_next = 1'b1;
            if (start_in) begin
                iss_phase_next = 1'b0;
                iss_word_next  = p0_first_word;
            end else begin
                iss_phase_next = 1'b1;
                iss_word_next  = '0;
            end
        end else if (cmd.scan && iss_active_reg) begin
            if (iss_last) begin
                iss_active_next = 1'b0;
            end else if (iss_at_end) begin
                iss_phase_next = 1'b1;
                iss_word_next  = '0;
            end else begin
                iss_word_next = iss_word_reg + WADDR_W'(1);
            end
        end
    end

    // A word whose row was never written reads as all free.
    assign cur_word = chk_row_valid_reg ? ram_rdata : '0;

    // Limits of the examined word within its scan part.
    assign lo_word = chk_phase_reg ? '0 : p0_first_word;
    assign lo_off  = chk_phase_reg ? '0 : p0_first_off;
    assign hi_word = chk_phase_reg ? p1_last_word : p0_last_word;
    assign hi_off  = chk_phase_reg ? p1_last_off : p0_last_off;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            scan_mask[i] = ((chk_word_reg != lo_word) || (OFF_W'(i) >= lo_off)) &&
                           ((chk_word_reg != hi_word) || (OFF_W'(i) <= hi_off));
        end
    end

    // Lowest free slot of the word: isolate the lowest set bit, then encode it.
    assign free_bits   = ~cur_word & scan_mask;
    assign lowest_free = free_bits & (~free_bits + WORD_W'(1));
    assign any_free    = |free_bits;

    always_comb begin
        pick_off = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (lowest_free[i]) begin
                pick_off = pick_off | OFF_W'(i);
            end
        end
    end

    // Bit store port: scan reads, free read-modify-write and allocate write-back.
    assign slot_word = WADDR_W'(slot_reg >> OFF_W);
    assign slot_off  = slot_reg[OFF_W-1:0];
    assign ram_we    = cmd.wr_alloc || cmd.wr_free;

    always_comb begin
        if (cmd.rd_free || cmd.wr_free) begin
            ram_addr = slot_word;
        end else if (cmd.wr_alloc) begin
            ram_addr = WADDR_W'(pick_slot_reg >> OFF_W);
        end else begin
            ram_addr = iss_word_reg;
        end
    end

    always_comb begin
        if (cmd.wr_alloc) begin
            ram_wdata = hold_word_reg | (WORD_W'(1) << pick_slot_reg[OFF_W-1:0]);
        end else begin
            ram_wdata = cur_word & ~(WORD_W'(1) << slot_off);
        end
    end

    nfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (nfsa_pkg::NUM_WORDS)
    ) u_bits (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Next allocator state and pending result.
    always_comb begin
        search_start_next = search_start_reg;
        used_count_next   = used_count_reg;
        res_ok_next       = res_ok_reg;
        res_slot_next     = res_slot_reg;
        if (cmd.wr_alloc) begin
            search_start_next = pick_slot_reg;
            used_count_next   = used_count_reg + COUNT_W'(1);
            res_ok_next       = 1'b1;
            res_slot_next     = pick_slot_reg;
        end else if (cmd.wr_free) begin
            search_start_next = slot_reg;
            if (used_count_reg != '0) begin
                used_count_next = used_count_reg - COUNT_W'(1);
            end
            res_ok_next   = 1'b1;
            res_slot_next = '0;
        end else if (cmd.set_fail) begin
            res_ok_next   = 1'b0;
            res_slot_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg   <= COUNT_W'(nfsa_pkg::SLOT_SPACE);
            search_start_reg <= '0;
            used_count_reg   <= '0;
            row_valid_reg    <= '0;
            iss_active_reg   <= 1'b0;
            chk_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            search_start_reg <= search_start_next;
            used_count_reg   <= used_count_next;
            if (ram_we) begin
                row_valid_reg[ram_addr] <= 1'b1;
            end
            iss_active_reg <= iss_active_next;
            chk_valid_reg  <= cmd.scan && iss_active_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
        end
        iss_word_reg      <= iss_word_next;
        iss_phase_reg     <= iss_phase_next;
        chk_word_reg      <= iss_word_reg;
        chk_phase_reg     <= iss_phase_reg;
        chk_last_reg      <= iss_last;
        chk_row_valid_reg <= row_valid_reg[ram_addr];
        if (cmd.scan && chk_valid_reg && any_free) begin
            hold_word_reg <= cur_word;
            pick_slot_reg <= SLOT_W'({chk_word_reg, pick_off});
        end
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        if (cmd.publish) begin
            out_ok_reg     <= res_ok_reg;
            out_slot_reg   <= res_slot_reg;
            out_in_use_reg <= used_count_reg;
        end
    end

    // Status towards the controller.
    assign status.op_free       = op_reg == nfsa_pkg::OP_FREE;
    assign status.full          = used_count_reg >= eff_n;
    assign status.free_in_range = COUNT_W'(slot_reg) < eff_n;
    assign status.hit           = chk_valid_reg && any_free;
    assign status.miss          = chk_valid_reg && !any_free && chk_last_reg;

    assign out_ok           = out_ok_reg;
    assign out_granted_slot = out_slot_reg;
    assign out_in_use       = out_in_use_reg;

`ifndef NO_ASSERTIONS
    // The in-use count never exceeds the pool size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= COUNT_W'(nfsa_pkg::EFF_MAX))
        else $error("in-use count exceeds the pool size");

    // A successful allocation raises the count by exactly one.
    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_alloc |=> used_count_reg == $past(used_count_reg) + COUNT_W'(1))
        else $error("allocation did not raise the in-use count by one");

    // A free moves the search start to the freed slot.
    a_free_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_free |=> search_start_reg == $past(slot_reg))
        else $error("free did not move the search start");
`endif

endmodule

// ----- hdl/nfsa_controller.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator controller
// Sequences one request at a time through decode, scan or read-modify-write,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module nfsa_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  nfsa_pkg::nfsa_status_t status,
    output nfsa_pkg::nfsa_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_ALLOC_WR = 3'd3;
    localparam logic [2:0] ST_FREE_RD  = 3'd4;
    localparam logic [2:0] ST_FREE_WR  = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       check_fail;

    // A request is refused at decode when the pool is full or the free is out of range.
    assign check_fail = status.op_free ? !status.free_in_range : status.full;

    // Commands decoded from the state.
    assign s_ready      = state_reg == ST_IDLE;
    assign cmd.load     = s_valid && s_ready;
    assign cmd.scan     = state_reg == ST_SCAN;
    assign cmd.rd_free  = state_reg == ST_FREE_RD;
    assign cmd.wr_free  = state_reg == ST_FREE_WR;
    assign cmd.wr_alloc = state_reg == ST_ALLOC_WR;
    assign cmd.set_fail = ((state_reg == ST_CHECK) && check_fail) ||
                          ((state_reg == ST_SCAN) && status.miss);
    assign cmd.publish  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (check_fail) begin
                    state_next = ST_DONE;
                end else if (status.op_free) begin
                    state_next = ST_FREE_RD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.hit) begin
                    state_next = ST_ALLOC_WR;
                end else if (status.miss) begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC_WR: state_next = ST_DONE;
            ST_FREE_RD:  state_next = ST_FREE_WR;
            ST_FREE_WR:  state_next = ST_DONE;
            ST_DONE: begin
                if (cmd.publish) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output beat valid: set on publish, cleared when taken.
    always_comb begin
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // A found free slot is always written back in the next cycle.
    a_hit_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && status.hit) |=> state_reg == ST_ALLOC_WR)
        else $error("found slot was not written back");

    // Every publish leaves a valid output beat behind it.
    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("published result not presented");
`endif

endmodule

// ----- hdl/next_fit_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator
// Top level: joins the request controller to the allocator datapath.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one result beat, and requests are handled one
// at a time. The in-use bits sit in a single-port RAM of 32 words of 32 slots,
// so an allocate reads one word per cycle. It examines the words from the start
// slot's word up to the word of the last slot and, after a wrap, from word 0 up
// to the start word again: at most 33 words at 1024 slots. A free is a
// read-modify-write of one word; a refused request (pool full, slot out of
// range) goes from decode to its result. A result is held until the previous
// one leaves the output register. A new request is taken while the previous
// result still waits in the output register. Every slot is free after reset with
// no clearing pass: each RAM word has a valid flag that reset clears. The slot
// count register may be written only while the block is idle.
module next_fit_slot_allocator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nfsa_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [nfsa_pkg::SLOT_W-1:0]  s_slot,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [nfsa_pkg::SLOT_W-1:0]  m_granted_slot,
    output logic [nfsa_pkg::COUNT_W-1:0] m_in_use
);

    nfsa_pkg::nfsa_cmd_t    cmd;
    nfsa_pkg::nfsa_status_t status;

    // Request sequencing.
    nfsa_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Bit store, scan and result datapath.
    nfsa_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_op            (s_op),
        .in_slot          (s_slot),
        .cmd              (cmd),
        .status           (status),
        .out_ok           (m_ok),
        .out_granted_slot (m_granted_slot),
        .out_in_use       (m_in_use)
    );

endmodule

// ----- dv/nfsa_checker.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator checker
// Watches the request, result and configuration ports of the allocator.
// Keeps its own copy of the in-use map, search start, in-use count and
// slot count. It works out the result of every accepted request beat,
// compares each result beat with the oldest outstanding expectation, and
// reports a failure count and the number of results still outstanding.
// ----------------------------------------------------------------------------
module nfsa_checker
    import nfsa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic [SLOT_W-1:0]  s_slot,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_ok,
    input  logic [SLOT_W-1:0]  m_granted_slot,
    input  logic [COUNT_W-1:0] m_in_use,
    output int                 errors,
    output int                 pending,
    output int                 grants,
    output int                 refusals,
    output int                 frees,
    output int                 ignored_frees
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] in_use;
    } alloc_result_t;

    // Model of the pool as the allocator should hold it.
    logic [SLOT_SPACE-1:0] taken_map;
    logic [SLOT_W-1:0]     next_start;
    logic [COUNT_W-1:0]    taken_count;
    logic [COUNT_W-1:0]    pool_size_reg;

    alloc_result_t expected_q[$];
    int            result_beats;

    // Applies one request to the pool model and returns the result it gives.
    function automatic alloc_result_t serve_request(input logic op,
                                                    input logic [SLOT_W-1:0] slot);
        int unsigned   limit;
        int unsigned   wrap_end;
        int unsigned   pick;
        logic          found;
        alloc_result_t res;
        limit = pool_size_reg;
        if (limit < 1) limit = 1;
        if (limit > EFF_MAX) limit = EFF_MAX;
        res = '0;
        found = 1'b0;
        pick = 0;
        if (op == OP_ALLOC) begin
            if (taken_count < limit) begin
                // Scan forward from the start slot, then wrap round once.
                if (next_start < limit) begin
                    for (int i = next_start; i < limit && !found; i++) begin
                        if (!taken_map[i]) begin
                            found = 1'b1;
                            pick = i;
                        end
                    end
                end
                if (!found && next_start != 0) begin
                    wrap_end = (next_start < limit) ? next_start : limit;
                    for (int i = 0; i < wrap_end && !found; i++) begin
                        if (!taken_map[i]) begin
                            found = 1'b1;
                            pick = i;
                        end
                    end
                end
                if (found) begin
                    taken_map[pick] = 1'b1;
                    next_start = pick[SLOT_W-1:0];
                    taken_count = taken_count + 1'b1;
                    res.ok = 1'b1;
                    res.slot = pick[SLOT_W-1:0];
                end
            end
        end else if (slot < limit) begin
            // A free of a slot that is already free still lowers the count.
            taken_map[slot] = 1'b0;
            next_start = slot;
            if (taken_count > 0) taken_count = taken_count - 1'b1;
            res.ok = 1'b1;
        end
        res.in_use = taken_count;
        return res;
    endfunction

    // Counts a failure and reports the first few of them in full.
    task automatic note_failure(input string what, input alloc_result_t want,
                                input alloc_result_t got);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("%t: %s on result beat %0d", $realtime, what, result_beats);
            $display("    expected ok=%0b slot=%0d in_use=%0d",
                     want.ok, want.slot, want.in_use);
            $display("    got      ok=%0b slot=%0d in_use=%0d",
                     got.ok, got.slot, got.in_use);
        end
    endtask

    // All port activity is taken at the rising edge.
    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (!aresetn) begin
            taken_map = '0;
            next_start = '0;
            taken_count = '0;
            pool_size_reg = COUNT_W'(1024);
            expected_q.delete();
            result_beats = 0;
            errors = 0;
            grants = 0;
            refusals = 0;
            frees = 0;
            ignored_frees = 0;
        end else begin
            // Result beat against the oldest expectation.
            if (m_valid && m_ready) begin
                got = '{m_ok, m_granted_slot, m_in_use};
                if (expected_q.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.ok !== want.ok || got.slot !== want.slot
                        || got.in_use !== want.in_use) begin
                        note_failure("mismatch", want, got);
                    end
                end
                result_beats++;
            end
            if (cfg_wr_en) pool_size_reg = cfg_wr_data;
            // Request beat: predict its result and tally what kind it was.
            if (s_valid && s_ready) begin
                want = serve_request(s_op, s_slot);
                expected_q.push_back(want);
                if (s_op == OP_ALLOC) begin
                    if (want.ok) grants++;
                    else refusals++;
                end else begin
                    if (want.ok) frees++;
                    else ignored_frees++;
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- dv/tb_next_fit_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator testbench
// Drives allocate and free requests into the allocator under random idling
// on both channels and across several slot counts, the extremes included.
// A directed opening covers the full pool, double frees, a scan that finds
// nothing, ignored frees and a search start beyond the pool; random phases
// follow. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_next_fit_slot_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nfsa_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [SLOT_W-1:0]  s_slot;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok;
    logic [SLOT_W-1:0]  m_granted_slot;
    logic [COUNT_W-1:0] m_in_use;

    int   errors;
    int   pending;
    int   grants;
    int   refusals;
    int   frees;
    int   ignored_frees;
    int   pool_settings = 0;
    int   stall_cycles = 0;
    logic calm = 1'b0;

    next_fit_slot_allocator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_granted_slot (m_granted_slot),
        .m_in_use       (m_in_use)
    );

    nfsa_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_granted_slot (m_granted_slot),
        .m_in_use       (m_in_use),
        .errors         (errors),
        .pending        (pending),
        .grants         (grants),
        .refusals       (refusals),
        .frees          (frees),
        .ignored_frees  (ignored_frees)
    );

    // Clock with a 12 ns period.
    always #6 aclk = ~aclk;

    // Result side: stalls about a third of the time, never in a calm stretch.
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("[next_fit_slot_allocator_top] ERROR");
                $finish;
            end
        end
    end

    // Sends one request beat, with random idle cycles ahead of it.
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot);
        if (!calm) begin
            while ($urandom_range(0, 99) < 34) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_slot <= slot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Holds back requests until every outstanding result has come out.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // Writes the slot count once the allocator has gone idle.
    task automatic write_slot_count(input logic [COUNT_W-1:0] value);
        wait_for_drain();
        repeat (6) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pool_settings++;
    endtask

    // Random requests against the given slot count. Most frees fall in the
    // low part of the pool, where allocations cluster; the rest are anywhere
    // or out of range.
    task automatic run_random_phase(input int unsigned items, input int unsigned alloc_pct,
                                    input int unsigned pool);
        int unsigned       limit;
        int unsigned       choice;
        logic              op;
        logic [SLOT_W-1:0] slot;
        limit = (pool < 1) ? 1 : (pool > EFF_MAX) ? EFF_MAX : pool;
        for (int k = 0; k < items; k++) begin
            op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                slot = SLOT_W'($urandom_range(0, (limit > 256) ? 255 : limit - 1));
            end else if (choice < 90) begin
                slot = SLOT_W'($urandom());
            end else begin
                slot = SLOT_W'($urandom_range((limit < SLOT_SPACE) ? limit : 0,
                                              SLOT_SPACE - 1));
            end
            send_request(op, slot);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_op = OP_ALLOC;
        s_slot = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full pool after reset: first grants, a free of the still free top slot,
        // a grant there and a wrapped search, then a double free of slot 0.
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd0);

        // Two-slot pool: fill it, hit the full case, then leave the count
        // below the number of set bits so that the scan finds nothing.
        write_slot_count(11'd2);
        send_request(OP_FREE, 10'd1);
        send_request(OP_FREE, 10'd0);
        send_request(OP_ALLOC, 10'd1023);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 10'd1);
        send_request(OP_FREE, 10'd1);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd1);

        // A zero count is taken as one slot; the search start now lies beyond it.
        write_slot_count(11'd0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 10'd1);

        // An oversized count is taken as the whole pool.
        write_slot_count(11'd2047);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 10'd1023);

        // Random phases over a spread of slot counts.
        write_slot_count(11'd8);
        run_random_phase(180, 60, 8);
        write_slot_count(11'd1);
        run_random_phase(80, 50, 1);
        write_slot_count(11'd1024);
        run_random_phase(110, 75, 1024);
        wait_for_drain();
        run_random_phase(110, 75, 1024);
        write_slot_count(11'd33);
        calm = 1'b1;
        run_random_phase(200, 55, 33);
        calm = 1'b0;
        write_slot_count(11'd2047);
        run_random_phase(180, 70, 2047);
        begin
            int unsigned pool;
            pool = $urandom_range(2, 64);
            write_slot_count(COUNT_W'(pool));
            run_random_phase(180, 60, pool);
        end

        // Let the last results out and allow for anything stray.
        wait_for_drain();
        repeat (100) @(negedge aclk);

        $display("Ran %0d slot count settings: %0d grants, %0d refused allocations,",
                 pool_settings, grants, refusals);
        $display("%0d frees and %0d out-of-range frees checked.", frees, ignored_frees);
        if (errors == 0 && pending == 0) begin
            $display("[next_fit_slot_allocator_top] OK");
        end else begin
            $display("[next_fit_slot_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
